/* src/bieu_pkg.sv */
// Package for the block instruction execute unit.
// Types and constants shared by the front end, queue and back end; no dependencies.
`timescale 1ns / 1ps
package bieu_pkg;

  typedef enum logic [4:0] {
    OP_BSTART_STD = 5'd0,
    OP_VPAR       = 5'd1,
    OP_VSEQ       = 5'd2,
    OP_BSTART     = 5'd3,
    OP_BSTOP      = 5'd4,
    OP_MOVI       = 5'd5,
    OP_LUI        = 5'd6,
    OP_HL_LUI     = 5'd7,
    OP_ADDI       = 5'd8,
    OP_LWI        = 5'd9,
    OP_SWI        = 5'd10,
    OP_SETC_NE    = 5'd11,
    OP_SETC_LTU   = 5'd12,
    OP_SSRSET     = 5'd13,
    OP_TMA_START  = 5'd14,
    OP_HL_SSRSET  = 5'd15
  } opcode_t;

  localparam logic [2:0] KIND_SCALAR = 3'd0;
  localparam logic [2:0] KIND_VPAR   = 3'd1;
  localparam logic [2:0] KIND_VSEQ   = 3'd2;
  localparam logic [2:0] KIND_TMA    = 3'd3;
  localparam logic [2:0] KIND_SYS    = 3'd4;

  localparam logic [1:0] BT_NONE   = 2'd0;
  localparam logic [1:0] BT_DIRECT = 2'd1;
  localparam logic [1:0] BT_COND   = 2'd2;

  localparam logic [4:0] TQ_BASE   = 5'd24;
  localparam logic [4:0] UQ_BASE   = 5'd28;
  localparam int         LUI_SHIFT = 12;

  localparam logic [1:0] REG_ENTRY_PC = 2'd0;
  localparam logic [1:0] REG_ACR      = 2'd1;

  typedef struct packed {
    logic [4:0]  op;
    logic [4:0]  rd;
    logic [4:0]  ra;
    logic [4:0]  rb;
    logic [63:0] imm;
    logic [3:0]  len;
    logic        direct;
    logic [11:0] ssr;
  } insn_t;

  typedef struct packed {
    logic [63:0] pc_after;
    logic [63:0] dest_value;
    logic        mem_valid;
    logic        mem_store;
    logic [63:0] mem_addr;
    logic [31:0] mem_data;
    logic [2:0]  blk_kind;
    logic        lane_index;
    logic        cond_flag;
  } result_t;

endpackage

/* src/block_isa_execute_unit.sv */
// Top level of the block instruction execute unit.
// Instantiates bieu_front and bieu_back; uses bieu_pkg; APB register port.
`timescale 1ns / 1ps
// Usage:
//  s_axis: one decoded instruction word per handshake. m_axis: one result word
//  per instruction, in order. APB: register 0 entry_pc (at 0x0, 64-bit data,
//  also reloads the pc), register 1 current_acr (at 0x8).
//  The front end queues up to two words. The back end handles each word in
//  two phases: a read phase for registers and the four byte-lane memory banks,
//  then a write phase that updates state and loads the output register. It
//  takes the next word from the queue only after the write phase of the last.
//  Reset clears the pc to 0, the config, general, tq and uq registers and
//  the queue. The data memory is then zeroed one word per cycle, DMEM_BYTES/4
//  words (1024 by default); words accepted meanwhile wait in the queue and
//  s_tready drops once it fills. When the receiver stalls the output register
//  holds its word; the back end waits and the queue fills, then s_tready drops.
module block_isa_execute_unit #(
  parameter int GPR_COUNT  = 24,
  parameter int SSR_COUNT  = 16,
  parameter int ACR_COUNT  = 4,
  parameter int DMEM_BYTES = 4096
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // opcode, dest_reg, src_a, src_b, immediate, insn_length, direct_target,
  // ssr_index, zero pad
  input  logic [87:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // pc_after, dest_value, mem_valid, mem_store, mem_addr, mem_data,
  // kind, lane_index, cond_flag, zero pad
  output logic [231:0] m_tdata,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);

  logic [63:0]       entry_pc;
  logic [1:0]        acr;
  logic              wr;
  logic              q_valid;
  logic              q_ready;
  bieu_pkg::insn_t   q_insn;
  bieu_pkg::result_t r;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_pc <= 64'd0;
      acr      <= 2'd0;
    end else if (wr) begin
      if (paddr[3] == bieu_pkg::REG_ENTRY_PC[0]) entry_pc <= pwdata;
      else acr <= pwdata[1:0];
    end
  end

  always_comb begin
    prdata = 64'd0;
    if (paddr[3] == bieu_pkg::REG_ACR[0]) prdata = {62'd0, acr};
    else if (paddr == 4'd0) prdata = entry_pc;
  end

  bieu_front u_front (
    .clk, .rst, .s_tvalid, .s_tready, .s_tdata,
    .q_valid, .q_ready, .q_insn
  );

  bieu_back #(
    .GPR_COUNT(GPR_COUNT), .SSR_COUNT(SSR_COUNT),
    .ACR_COUNT(ACR_COUNT), .DMEM_BYTES(DMEM_BYTES)
  ) u_back (
    .clk, .rst, .q_valid, .q_ready, .q_insn,
    .cfg_pc_wr (wr && paddr == 4'd0),
    .cfg_pc    (pwdata),
    .acr,
    .r_valid   (m_tvalid),
    .r_ready   (m_tready),
    .r_data    (r)
  );

  assign m_tdata = {1'b0, r.cond_flag, r.lane_index, r.blk_kind, r.mem_data,
                    r.mem_addr, r.mem_store, r.mem_valid, r.dest_value, r.pc_after};

endmodule

/* src/bieu_front.sv */
// Front end: accepts decoded words, sign-extends the immediate and queues them.
// Depends on bieu_pkg. Two-entry queue towards the back end.
`timescale 1ns / 1ps
module bieu_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [87:0]          s_tdata,
  output logic                 q_valid,
  input  logic                 q_ready,
  output bieu_pkg::insn_t      q_insn
);

  bieu_pkg::insn_t fifo [2];
  logic            wptr;
  logic            rptr;
  logic [1:0]      count;
  bieu_pkg::insn_t in_insn;
  logic            push;
  logic            pop;

  always_comb begin
    in_insn.op     = s_tdata[4:0];
    in_insn.rd     = s_tdata[9:5];
    in_insn.ra     = s_tdata[14:10];
    in_insn.rb     = s_tdata[19:15];
    in_insn.imm    = {{16{s_tdata[67]}}, s_tdata[67:20]};
    in_insn.len    = s_tdata[71:68];
    in_insn.direct = s_tdata[72];
    in_insn.ssr    = s_tdata[84:73];
  end

  assign s_tready = (count != 2'd2);
  assign push     = s_tvalid && s_tready;
  assign q_valid  = (count != 2'd0);
  assign pop      = q_valid && q_ready;
  assign q_insn   = fifo[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      fifo[wptr] <= in_insn;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wptr <= ~wptr;
      if (pop) rptr <= ~rptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  assert property (@(posedge clk) disable iff (rst) count <= 2'd2)
    else $error("queue overflow");
  assert property (@(posedge clk) disable iff (rst) (push && !pop) |=> count != 2'd0)
    else $error("push lost");
  assert property (@(posedge clk) disable iff (rst) (pop && !push) |=> count != 2'd2)
    else $error("pop lost");

endmodule

/* src/bieu_back.sv */
// Back end: two-phase execution (register/memory read, then write and result).
// Depends on bieu_pkg. Holds architectural state and the byte data memory.
`timescale 1ns / 1ps
module bieu_back #(
  parameter int GPR_COUNT  = 24,
  parameter int SSR_COUNT  = 16,
  parameter int ACR_COUNT  = 4,
  parameter int DMEM_BYTES = 4096
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 q_valid,
  output logic                 q_ready,
  input  bieu_pkg::insn_t      q_insn,
  input  logic                 cfg_pc_wr,
  input  logic [63:0]          cfg_pc,
  input  logic [1:0]           acr,
  output logic                 r_valid,
  input  logic                 r_ready,
  output bieu_pkg::result_t    r_data
);

  localparam int AW  = $clog2(DMEM_BYTES);
  localparam int WW  = AW - 2 > 0 ? AW - 2 : 1;
  localparam int SRN = SSR_COUNT * ACR_COUNT;
  localparam int SAW = SRN > 1 ? $clog2(SRN) : 1;

  logic [63:0] gpr [GPR_COUNT];
  logic [63:0] tq [4];
  logic [63:0] uq [4];
  logic [63:0] sys_regs [SRN];
  logic [7:0]  mem0 [DMEM_BYTES/4];
  logic [7:0]  mem1 [DMEM_BYTES/4];
  logic [7:0]  mem2 [DMEM_BYTES/4];
  logic [7:0]  mem3 [DMEM_BYTES/4];
  logic          clearing;
  logic [WW-1:0] clr_idx;

  logic [63:0] pc;
  logic [63:0] block_target;
  logic [1:0]  block_type;
  logic        cond_bit;
  logic [2:0]  kind_reg;

  logic              busy;
  bieu_pkg::insn_t   cur;
  logic [63:0]       va;
  logic [63:0]       vb;
  logic [31:0]       rdata;
  logic              rdok;
  logic [63:0]       addr_r;

  logic              out_full;

  function automatic logic [63:0] rd_reg(input logic [4:0] i,
      input logic [63:0] g [GPR_COUNT], input logic [63:0] t [4], input logic [63:0] u [4]);
    logic [63:0] v;
    v = 64'd0;
    if (i >= bieu_pkg::UQ_BASE) v = u[i[1:0]];
    else if (i >= bieu_pkg::TQ_BASE) v = t[i[1:0]];
    else if (i != 5'd0 && 32'(i) < GPR_COUNT) v = g[i];
    return v;
  endfunction

  // phase 1 addresses (from queue head)
  logic [63:0] a_q;
  logic [63:0] b_q;
  logic [63:0] base_q;
  logic [63:0] ea_q;
  logic        inr_q;
  logic [WW-1:0] widx_q;
  logic [1:0]  boff_q;

  always_comb begin
    a_q    = rd_reg(q_insn.ra, gpr, tq, uq);
    b_q    = rd_reg(q_insn.rb, gpr, tq, uq);
    base_q = (q_insn.op == bieu_pkg::OP_SWI) ? b_q : a_q;
    ea_q   = base_q + q_insn.imm;
    inr_q  = ea_q <= 64'(DMEM_BYTES - 4);
    widx_q = ea_q[AW-1:2];
    boff_q = ea_q[1:0];
  end

  // byte lanes: bytes ea..ea+3 span word widx and widx+1
  logic [WW-1:0] li [4];
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      li[k] = (k < 32'(boff_q)) ? widx_q + WW'(1) : widx_q;
    end
  end

  logic [7:0] rb0, rb1, rb2, rb3;
  logic       fire1;
  assign q_ready = !busy && !clearing;
  assign fire1   = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (fire1) begin
      rb0 <= mem0[li[0]];
      rb1 <= mem1[li[1]];
      rb2 <= mem2[li[2]];
      rb3 <= mem3[li[3]];
      cur    <= q_insn;
      va     <= a_q;
      vb     <= b_q;
      rdok   <= inr_q;
      addr_r <= ea_q;
    end
  end

  logic [7:0] lane [4];
  always_comb begin
    lane[0] = rb0;
    lane[1] = rb1;
    lane[2] = rb2;
    lane[3] = rb3;
    unique case (addr_r[1:0])
      2'd0: rdata = {lane[3], lane[2], lane[1], lane[0]};
      2'd1: rdata = {lane[0], lane[3], lane[2], lane[1]};
      2'd2: rdata = {lane[1], lane[0], lane[3], lane[2]};
      default: rdata = {lane[2], lane[1], lane[0], lane[3]};
    endcase
  end

  // phase 2
  logic        fire2;
  assign fire2 = busy && !out_full;

  logic [63:0] pc_next;
  logic [63:0] wval;
  logic        wen;
  logic [4:0]  wdst;
  logic [2:0]  kind;
  logic [1:0]  bt_next;
  logic        cb_next;
  logic [63:0] bt_tgt_next;
  logic [31:0] ldata;
  logic        st_en;
  logic        ssr_en;
  logic [2:0]  kr_next;

  always_comb begin
    kind = kind_reg;
    unique case (cur.op)
      bieu_pkg::OP_VPAR:      kind = bieu_pkg::KIND_VPAR;
      bieu_pkg::OP_VSEQ:      kind = bieu_pkg::KIND_VSEQ;
      bieu_pkg::OP_TMA_START: kind = bieu_pkg::KIND_TMA;
      bieu_pkg::OP_SSRSET, bieu_pkg::OP_HL_SSRSET: kind = bieu_pkg::KIND_SYS;
      default: kind = kind_reg;
    endcase
    kr_next     = kind;
    pc_next     = pc + {60'd0, cur.len};
    wval        = 64'd0;
    wen         = 1'b0;
    wdst        = cur.rd;
    bt_next     = block_type;
    cb_next     = cond_bit;
    bt_tgt_next = block_target;
    ldata       = rdok ? rdata : 32'd0;
    st_en       = 1'b0;
    ssr_en      = 1'b0;
    unique case (cur.op)
      bieu_pkg::OP_BSTART_STD: begin
        bt_next = bieu_pkg::BT_NONE;
        kr_next = bieu_pkg::KIND_SCALAR;
      end
      bieu_pkg::OP_BSTART: begin
        bt_tgt_next = pc + {cur.imm[62:0], 1'b0};
        bt_next     = cur.direct ? bieu_pkg::BT_DIRECT : bieu_pkg::BT_COND;
      end
      bieu_pkg::OP_BSTOP: begin
        if (block_type == bieu_pkg::BT_DIRECT ||
            (block_type == bieu_pkg::BT_COND && cond_bit)) pc_next = block_target;
        bt_next = bieu_pkg::BT_NONE;
        cb_next = 1'b0;
      end
      bieu_pkg::OP_MOVI: begin
        wen = 1'b1; wval = cur.imm;
      end
      bieu_pkg::OP_LUI: begin
        wen = 1'b1; wval = cur.imm << bieu_pkg::LUI_SHIFT;
      end
      bieu_pkg::OP_HL_LUI: begin
        wen = 1'b1; wval = cur.imm;
        if (32'(cur.rd) >= GPR_COUNT) wdst = bieu_pkg::TQ_BASE;
      end
      bieu_pkg::OP_ADDI: begin
        wen = 1'b1; wval = va + cur.imm;
      end
      bieu_pkg::OP_LWI: begin
        wen = 1'b1; wval = {32'd0, ldata};
      end
      bieu_pkg::OP_SWI: st_en = rdok;
      bieu_pkg::OP_SETC_NE:  cb_next = va != vb;
      bieu_pkg::OP_SETC_LTU: cb_next = va < vb;
      bieu_pkg::OP_SSRSET:
        ssr_en = (32'(cur.ssr) < SSR_COUNT) && (32'(acr) < ACR_COUNT);
      default: ;
    endcase
  end

  logic wr_ok;
  assign wr_ok = wen && (wdst >= bieu_pkg::TQ_BASE ||
                         (wdst != 5'd0 && 32'(wdst) < GPR_COUNT));

  logic [WW-1:0] sw [4];
  logic [1:0]    so;
  logic [31:0]   sd;
  assign so = addr_r[1:0];
  assign sd = va[31:0];
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      sw[k] = (k < 32'(so)) ? addr_r[AW-1:2] + WW'(1) : addr_r[AW-1:2];
    end
  end

  // byte for physical lane k is data byte (k - so) mod 4
  function automatic logic [7:0] sbyte(input logic [31:0] d, input logic [1:0] k,
                                      input logic [1:0] o);
    logic [1:0] j;
    j = k - o;
    return d[8*j +: 8];
  endfunction

  // after reset the banks are zeroed one word per cycle
  always_ff @(posedge clk) begin
    if (clearing) begin
      mem0[clr_idx] <= 8'd0;
      mem1[clr_idx] <= 8'd0;
      mem2[clr_idx] <= 8'd0;
      mem3[clr_idx] <= 8'd0;
    end else if (fire2 && st_en) begin
      mem0[sw[0]] <= sbyte(sd, 2'd0, so);
      mem1[sw[1]] <= sbyte(sd, 2'd1, so);
      mem2[sw[2]] <= sbyte(sd, 2'd2, so);
      mem3[sw[3]] <= sbyte(sd, 2'd3, so);
    end
  end

  logic [SAW-1:0] ssr_addr;
  assign ssr_addr = SAW'(32'(acr) * SSR_COUNT + 32'(cur.ssr));
  always_ff @(posedge clk) begin
    if (fire2 && ssr_en) sys_regs[ssr_addr] <= va;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy         <= 1'b0;
      pc           <= 64'd0;
      block_target <= 64'd0;
      block_type   <= bieu_pkg::BT_NONE;
      cond_bit     <= 1'b0;
      kind_reg     <= bieu_pkg::KIND_SCALAR;
      out_full     <= 1'b0;
      clearing     <= 1'b1;
      clr_idx      <= '0;
      for (int k = 0; k < GPR_COUNT; k++) gpr[k] <= 64'd0;
      for (int k = 0; k < 4; k++) begin
        tq[k] <= 64'd0;
        uq[k] <= 64'd0;
      end
    end else begin
      if (clearing) begin
        clr_idx <= clr_idx + WW'(1);
        if (clr_idx == WW'(DMEM_BYTES/4 - 1)) clearing <= 1'b0;
      end
      if (fire1) busy <= 1'b1;
      else if (fire2) busy <= 1'b0;
      if (r_valid && r_ready) out_full <= 1'b0;
      if (cfg_pc_wr) pc <= cfg_pc;
      if (fire2) begin
        out_full     <= 1'b1;
        pc           <= pc_next;
        block_target <= bt_tgt_next;
        block_type   <= bt_next;
        cond_bit     <= cb_next;
        kind_reg     <= kr_next;
        if (wr_ok) begin
          if (wdst >= bieu_pkg::UQ_BASE) uq[wdst[1:0]] <= wval;
          else if (wdst >= bieu_pkg::TQ_BASE) tq[wdst[1:0]] <= wval;
          else gpr[wdst] <= wval;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire2) begin
      r_data.pc_after   <= pc_next;
      r_data.dest_value <= wr_ok ? wval : 64'd0;
      r_data.mem_valid  <= cur.op == bieu_pkg::OP_LWI || cur.op == bieu_pkg::OP_SWI;
      r_data.mem_store  <= cur.op == bieu_pkg::OP_SWI;
      r_data.mem_addr   <= (cur.op == bieu_pkg::OP_LWI || cur.op == bieu_pkg::OP_SWI)
                           ? addr_r : 64'd0;
      r_data.mem_data   <= cur.op == bieu_pkg::OP_LWI ? ldata :
                           cur.op == bieu_pkg::OP_SWI ? sd : 32'd0;
      r_data.blk_kind   <= kind;
      r_data.lane_index <= !(kind == bieu_pkg::KIND_VPAR || kind == bieu_pkg::KIND_VSEQ);
      r_data.cond_flag  <= cb_next;
    end
  end

  assign r_valid = out_full;

  assert property (@(posedge clk) disable iff (rst) fire2 |=> r_valid)
    else $error("result not presented");
  assert property (@(posedge clk) disable iff (rst) (r_valid && !r_ready) |=> r_valid)
    else $error("result dropped");
  assert property (@(posedge clk) disable iff (rst) fire1 |=> busy)
    else $error("issue lost");

endmodule

/* bench/tb_top.sv */
// Self-checking testbench for block_isa_execute_unit: directed table, then random words.
// Carries its own model of the execute stage; depends on bieu_pkg and the RTL only.
`timescale 1ns / 1ps
module tb_top;

  localparam logic [4:0] OP_OTHER = 5'd16;
  localparam int LIMIT_CYCLES = 400000;

  logic clk, rst;
  logic s_tvalid, s_tready, m_tvalid, m_tready;
  logic [87:0] s_tdata;
  logic [231:0] m_tdata;
  logic psel, penable, pwrite, pready;
  logic [3:0] paddr;
  logic [63:0] pwdata, prdata;

  block_isa_execute_unit u_top (.*);

  // architectural copy
  logic [63:0] cfg_entry_pc;
  logic [1:0]  cfg_acr;
  logic [63:0] pc, blk_target;
  logic [63:0] gpr[24];
  logic [63:0] tq[4];
  logic [63:0] uq[4];
  logic [63:0] ssr_bank[64];
  logic [7:0]  dmem[4096];
  logic [1:0]  blk_type;
  logic        cond_bit;
  logic [2:0]  kind_reg;

  bieu_pkg::result_t expected_q[$];
  int errors, cycles;

  typedef struct {
    logic [4:0]  op;
    logic [4:0]  rd, ra, rb;
    logic [47:0] imm;
    logic [3:0]  len;
    logic        direct;
    logic [11:0] ssr;
  } tb_insn_t;

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic logic [63:0] reg_rd(logic [4:0] idx);
    if (idx >= 1 && idx < 24) return gpr[idx];
    if (idx >= bieu_pkg::TQ_BASE && idx < bieu_pkg::UQ_BASE) return tq[idx - bieu_pkg::TQ_BASE];
    if (idx >= bieu_pkg::UQ_BASE) return uq[idx - bieu_pkg::UQ_BASE];
    return 64'd0;
  endfunction

  task automatic reg_wr(logic [4:0] idx, logic [63:0] v);
    if (idx >= 1 && idx < 24) gpr[idx] = v;
    else if (idx >= bieu_pkg::TQ_BASE && idx < bieu_pkg::UQ_BASE) tq[idx - bieu_pkg::TQ_BASE] = v;
    else if (idx >= bieu_pkg::UQ_BASE) uq[idx - bieu_pkg::UQ_BASE] = v;
  endtask

  task automatic clear_state();
    pc = cfg_entry_pc;
    blk_target = 0; blk_type = bieu_pkg::BT_NONE; cond_bit = 0;
    kind_reg = bieu_pkg::KIND_SCALAR;
    foreach (gpr[i]) gpr[i] = 0;
    foreach (tq[i]) begin tq[i] = 0; uq[i] = 0; end
    foreach (ssr_bank[i]) ssr_bank[i] = 0;
    foreach (dmem[i]) dmem[i] = 0;
  endtask

  task automatic execute_insn(tb_insn_t w, output bieu_pkg::result_t r);
    logic [63:0] imm, cur, a, b;
    logic [2:0]  kind;
    imm = {{16{w.imm[47]}}, w.imm};
    cur = pc;
    r = '0;
    kind = kind_reg;
    case (w.op)
      bieu_pkg::OP_VPAR: kind = bieu_pkg::KIND_VPAR;
      bieu_pkg::OP_VSEQ: kind = bieu_pkg::KIND_VSEQ;
      bieu_pkg::OP_TMA_START: kind = bieu_pkg::KIND_TMA;
      bieu_pkg::OP_SSRSET, bieu_pkg::OP_HL_SSRSET: kind = bieu_pkg::KIND_SYS;
      default: ;
    endcase
    r.blk_kind = kind;
    r.lane_index = !(kind == bieu_pkg::KIND_VPAR || kind == bieu_pkg::KIND_VSEQ);
    kind_reg = kind;
    pc = cur + 64'(w.len);
    case (w.op)
      bieu_pkg::OP_BSTART_STD: begin
        blk_type = bieu_pkg::BT_NONE;
        kind_reg = bieu_pkg::KIND_SCALAR;
      end
      bieu_pkg::OP_BSTART: begin
        blk_target = cur + (imm << 1);
        blk_type = w.direct ? bieu_pkg::BT_DIRECT : bieu_pkg::BT_COND;
      end
      bieu_pkg::OP_BSTOP: begin
        if (blk_type == bieu_pkg::BT_DIRECT || (blk_type == bieu_pkg::BT_COND && cond_bit))
          pc = blk_target;
        blk_type = bieu_pkg::BT_NONE;
        cond_bit = 0;
      end
      bieu_pkg::OP_MOVI: begin
        reg_wr(w.rd, imm);
        r.dest_value = reg_rd(w.rd);
      end
      bieu_pkg::OP_LUI: begin
        reg_wr(w.rd, imm << bieu_pkg::LUI_SHIFT);
        r.dest_value = reg_rd(w.rd);
      end
      bieu_pkg::OP_HL_LUI: begin
        if (w.rd >= 24) begin
          tq[0] = imm;
          r.dest_value = tq[0];
        end else begin
          reg_wr(w.rd, imm);
          r.dest_value = reg_rd(w.rd);
        end
      end
      bieu_pkg::OP_ADDI: begin
        reg_wr(w.rd, reg_rd(w.ra) + imm);
        r.dest_value = reg_rd(w.rd);
      end
      bieu_pkg::OP_LWI: begin
        r.mem_addr = reg_rd(w.ra) + imm;
        if (r.mem_addr <= 64'd4092)
          for (int i = 0; i < 4; i++) r.mem_data[8*i +: 8] = dmem[r.mem_addr + i];
        reg_wr(w.rd, {32'd0, r.mem_data});
        r.dest_value = reg_rd(w.rd);
        r.mem_valid = 1;
      end
      bieu_pkg::OP_SWI: begin
        a = reg_rd(w.ra);
        r.mem_data = a[31:0];
        r.mem_addr = reg_rd(w.rb) + imm;
        if (r.mem_addr <= 64'd4092)
          for (int i = 0; i < 4; i++) dmem[r.mem_addr + i] = r.mem_data[8*i +: 8];
        r.mem_valid = 1;
        r.mem_store = 1;
      end
      bieu_pkg::OP_SETC_NE, bieu_pkg::OP_SETC_LTU: begin
        a = reg_rd(w.ra);
        b = reg_rd(w.rb);
        cond_bit = (w.op == bieu_pkg::OP_SETC_NE) ? (a != b) : (a < b);
      end
      bieu_pkg::OP_SSRSET: if (w.ssr < 16) ssr_bank[cfg_acr * 16 + w.ssr] = reg_rd(w.ra);
      default: ;
    endcase
    r.pc_after = pc;
    r.cond_flag = cond_bit;
  endtask

  // sender
  task automatic send_word(tb_insn_t w, bit typed = 0, logic [63:0] t_pc = 0,
                           logic [63:0] t_dval = 0);
    bieu_pkg::result_t r;
    int gap;
    s_tvalid <= 1;
    s_tdata <= {3'd0, w.ssr, w.direct, w.len, w.imm, w.rb, w.ra, w.rd, w.op};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    execute_insn(w, r);
    if (typed) begin
      r.pc_after = t_pc;
      r.dest_value = t_dval;
    end
    expected_q.push_back(r);
    gap = ($urandom_range(0, 2) == 0) ? 0 :
          ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 3);
    if (gap > 0) begin
      s_tvalid <= 0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain();
    s_tvalid <= 0;
    @(posedge clk);
    while (expected_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic apb_write(logic [3:0] addr, logic [63:0] data);
    psel <= 1; pwrite <= 1; penable <= 0; paddr <= addr; pwdata <= data;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
    if (addr == 4'h0) begin
      cfg_entry_pc = data;
      pc = data;
    end else begin
      cfg_acr = data[1:0];
    end
    @(posedge clk);
  endtask

  function automatic tb_insn_t random_word();
    tb_insn_t w;
    int sel;
    sel = $urandom_range(0, 99);
    w.op = (sel < 90) ? 5'($urandom_range(0, 16)) : 5'($urandom_range(17, 31));
    if ($urandom_range(0, 3) == 0)
      w.op = ($urandom_range(0, 1) == 0) ? bieu_pkg::OP_LWI : bieu_pkg::OP_SWI;
    w.rd = 5'($urandom_range(0, 31));
    w.ra = 5'($urandom_range(0, 31));
    w.rb = 5'($urandom_range(0, 31));
    case ($urandom_range(0, 3))
      0: w.imm = 48'({$urandom(), $urandom()});
      1: w.imm = 48'($signed($urandom_range(0, 128)) - 64);
      default: w.imm = 48'($urandom_range(0, 4100));
    endcase
    if ((w.op == bieu_pkg::OP_LWI || w.op == bieu_pkg::OP_SWI) && $urandom_range(0, 2) != 0) begin
      w.ra = (w.op == bieu_pkg::OP_LWI) ? 5'd0 : w.ra;
      w.rb = 5'd0;
    end
    w.len = ($urandom_range(0, 7) == 0) ? 4'($urandom_range(0, 15))
                                        : 4'(2 * $urandom_range(1, 4));
    w.direct = 1'($urandom_range(0, 1));
    w.ssr = ($urandom_range(0, 3) == 0) ? 12'($urandom_range(0, 4095))
                                        : 12'($urandom_range(0, 20));
    return w;
  endfunction

  // receiver
  int stall_left;
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 0;
      stall_left <= 0;
    end else begin
      if (stall_left > 0) begin
        m_tready <= 0;
        stall_left <= stall_left - 1;
      end else begin
        m_tready <= 1;
        if ($urandom_range(0, 3) == 0)
          stall_left <= ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40)
                                                     : $urandom_range(1, 3);
      end
    end
  end

  task automatic check_field(string name, logic [63:0] exp_v, logic [63:0] got_v,
                             inout bit bad);
    if (exp_v !== got_v) begin
      if (errors < 10)
        $display("mismatch %s: expected %h got %h at %0t", name, exp_v, got_v, $realtime);
      bad = 1;
    end
  endtask

  always @(posedge clk) begin
    bieu_pkg::result_t e;
    bit bad;
    if (!rst && m_tvalid && m_tready) begin
      bad = 0;
      if (expected_q.size() == 0) begin
        if (errors < 10) $display("unexpected result word at %0t", $realtime);
        errors++;
      end else begin
        e = expected_q.pop_front();
        check_field("pc_after", e.pc_after, m_tdata[63:0], bad);
        check_field("dest_value", e.dest_value, m_tdata[127:64], bad);
        check_field("mem_valid", 64'(e.mem_valid), 64'(m_tdata[128]), bad);
        check_field("mem_store", 64'(e.mem_store), 64'(m_tdata[129]), bad);
        check_field("mem_addr", e.mem_addr, m_tdata[193:130], bad);
        check_field("mem_data", 64'(e.mem_data), 64'(m_tdata[225:194]), bad);
        check_field("blk_kind", 64'(e.blk_kind), 64'(m_tdata[228:226]), bad);
        check_field("lane_index", 64'(e.lane_index), 64'(m_tdata[229]), bad);
        check_field("cond_flag", 64'(e.cond_flag), 64'(m_tdata[230]), bad);
        if (bad) errors++;
      end
    end
  end

  typedef struct {
    tb_insn_t    w;
    bit          typed;
    logic [63:0] t_pc, t_dval;
  } row_t;

  function automatic row_t mk(logic [4:0] op, logic [4:0] rd, logic [4:0] ra,
                              logic [4:0] rb, logic [47:0] imm, logic [3:0] len,
                              logic direct = 0, logic [11:0] ssr = 0, bit typed = 0,
                              logic [63:0] t_pc = 0, logic [63:0] t_dval = 0);
    row_t r;
    r.w = '{op, rd, ra, rb, imm, len, direct, ssr};
    r.typed = typed; r.t_pc = t_pc; r.t_dval = t_dval;
    return r;
  endfunction

  row_t dir_rows[$];

  initial begin
    rst = 1; s_tvalid = 0; s_tdata = '0;
    psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
    errors = 0; cycles = 0;
    cfg_entry_pc = 0; cfg_acr = 0;
    clear_state();
    repeat (3) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    dir_rows = '{
      mk(bieu_pkg::OP_MOVI, 1, 0, 0, 48'hFFFF_FFFF_FFFF, 2, 0, 0, 1, 64'd2, '1),
      mk(bieu_pkg::OP_LUI, 2, 0, 0, 48'd1, 4, 0, 0, 1, 64'd6, 64'h1000),
      mk(bieu_pkg::OP_HL_LUI, 31, 0, 0, 48'h7FFF_FFFF_FFFF, 8, 0, 0, 1, 64'd14,
         64'h0000_7FFF_FFFF_FFFF),
      mk(bieu_pkg::OP_ADDI, 3, 1, 0, 48'd1, 2, 0, 0, 1, 64'd16, 64'd0),
      mk(bieu_pkg::OP_SWI, 0, 1, 0, 48'd0, 4),
      mk(bieu_pkg::OP_LWI, 4, 0, 0, 48'd0, 4),
      mk(bieu_pkg::OP_SWI, 0, 1, 0, 48'd4093, 4),
      mk(bieu_pkg::OP_LWI, 5, 0, 0, 48'd4093, 4),
      mk(bieu_pkg::OP_SWI, 0, 2, 0, 48'd4092, 4),
      mk(bieu_pkg::OP_LWI, 6, 0, 0, 48'd4092, 4),
      mk(bieu_pkg::OP_SETC_NE, 0, 1, 0, 48'd0, 2),
      mk(bieu_pkg::OP_BSTART, 0, 0, 0, 48'd5, 4, 0),
      mk(bieu_pkg::OP_BSTOP, 0, 0, 0, 48'd0, 2),
      mk(bieu_pkg::OP_SETC_LTU, 0, 0, 1, 48'd0, 2),
      mk(bieu_pkg::OP_BSTART, 0, 0, 0, 48'h8000_0000_0000, 6, 1),
      mk(bieu_pkg::OP_BSTOP, 0, 0, 0, 48'd0, 2),
      mk(bieu_pkg::OP_BSTOP, 0, 0, 0, 48'd0, 8),
      mk(bieu_pkg::OP_VPAR, 0, 0, 0, 48'd0, 4),
      mk(bieu_pkg::OP_VSEQ, 0, 0, 0, 48'd0, 4),
      mk(bieu_pkg::OP_TMA_START, 0, 0, 0, 48'd0, 4),
      mk(bieu_pkg::OP_SSRSET, 0, 1, 0, 48'd0, 4, 0, 12'd3),
      mk(bieu_pkg::OP_SSRSET, 0, 1, 0, 48'd0, 4, 0, 12'hFFF),
      mk(bieu_pkg::OP_HL_SSRSET, 0, 1, 0, 48'd0, 6),
      mk(bieu_pkg::OP_BSTART_STD, 0, 0, 0, 48'd0, 4),
      mk(OP_OTHER, 24, 31, 31, 48'd0, 15),
      mk(bieu_pkg::OP_MOVI, 0, 0, 0, 48'd7, 0, 0, 0, 1, 64'hFFFF_0000_0000_006B, 64'd0)
    };
    foreach (dir_rows[i])
      send_word(dir_rows[i].w, dir_rows[i].typed, dir_rows[i].t_pc, dir_rows[i].t_dval);

    for (int phase = 0; phase < 4; phase++) begin
      drain();
      case (phase)
        0: begin apb_write(4'h0, '1); apb_write(4'h8, 64'd3); end
        1: begin apb_write(4'h0, 64'd0); apb_write(4'h8, 64'd0); end
        2: begin apb_write(4'h0, {$urandom(), $urandom()}); apb_write(4'h8, 64'd1); end
        default: begin apb_write(4'h0, 64'd256); apb_write(4'h8, 64'd2); end
      endcase
      for (int n = 0; n < 270; n++) begin
        if (phase == 1 && n == 135) drain();
        send_word(random_word());
      end
    end

    drain();
    repeat (20) @(posedge clk);
    if (errors == 0 && expected_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
